[rtl/core/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    localparam int DefaultDepth = 16;
    localparam int ValueWidth   = 32;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef struct packed {
        logic                         action;
        logic signed [ValueWidth-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [ValueWidth-1:0] smallest;
        logic                         is_empty;
        logic                         is_full;
        logic                         dropped;
    } t_out_beat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue: fill count, cell chain, result register.
// Depends on spq_pkg and spq_cell.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------
//  input    | i_in_valid  | o_in_stall  | i_in_data  (t_in_beat)
//  output   | o_out_valid | i_out_stall | o_out_data (t_out_beat)
//
// One beat per cycle while not stalled: every cell compares its entry with the
// pushed value in parallel and shifts in that cycle; the result is out next cycle.
// Reset clears the fill count and the result valid; entries need no clearing.
// Input stalls only while a result is held and the output side stalls.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DefaultDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_beat     r_out_data;
    t_out_beat     n_out_data;

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic          w_push;
    logic          w_pop;
    logic          w_drop;
    t_cell_ctl     w_ctl;

    logic                         w_gt    [DEPTH];
    logic signed [ValueWidth-1:0] w_entry [DEPTH];
    logic signed [ValueWidth-1:0] w_next  [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_push     = w_accept && (i_in_data.action == ACT_PUSH) && !w_full;
    assign w_pop      = w_accept && (i_in_data.action == ACT_POP) && !w_empty;
    assign w_drop     = w_accept && (i_in_data.action == ACT_PUSH) && w_full;
    assign w_ctl      = '{push: w_push, pop: w_pop};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                         w_lgt;
        logic signed [ValueWidth-1:0] w_lent;
        logic signed [ValueWidth-1:0] w_rent;

        if (g == 0) begin : g_first
            assign w_lgt  = 1'b0;
            assign w_lent = i_in_data.value;
        end else begin : g_mid
            assign w_lgt  = w_gt[g-1];
            assign w_lent = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rent = w_entry[g];
        end else begin : g_inner
            assign w_rent = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_value       (i_in_data.value),
            .i_occ         (CW'(g) < r_count),
            .i_left_gt     (w_lgt),
            .i_left_entry  (w_lent),
            .i_right_entry (w_rent),
            .o_gt          (w_gt[g]),
            .o_entry       (w_entry[g]),
            .o_next        (w_next[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CW'(1);
        end else if (w_pop) begin
            n_count = r_count - CW'(1);
        end
        n_out_data.smallest = (n_count == '0) ? '0 : w_next[0];
        n_out_data.is_empty = (n_count == '0);
        n_out_data.is_full  = (n_count == CW'(DEPTH));
        n_out_data.dropped  = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dropped) |-> (o_out_data.is_full && !o_out_data.is_empty))
        else $error("drop reported while not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |-> (o_out_data.smallest == '0))
        else $error("empty result carries nonzero value");

endmodule

[rtl/core/spq_cell.sv]
// One slot of the sorted store: holds an entry and shifts it to a neighbor.
// Depends on spq_pkg for the cell control struct and value width.
module spq_cell
    import spq_pkg::*;
(
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [ValueWidth-1:0] i_value,
    input  logic                         i_occ,
    input  logic                         i_left_gt,
    input  logic signed [ValueWidth-1:0] i_left_entry,
    input  logic signed [ValueWidth-1:0] i_right_entry,
    output logic                         o_gt,
    output logic signed [ValueWidth-1:0] o_entry,
    output logic signed [ValueWidth-1:0] o_next
);

    logic signed [ValueWidth-1:0] r_entry;
    logic signed [ValueWidth-1:0] n_entry;

    assign o_gt    = !i_occ || (r_entry > i_value);
    assign o_entry = r_entry;
    assign o_next  = n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (o_gt && !i_left_gt) begin
                n_entry = i_value;
            end else if (o_gt) begin
                n_entry = i_left_entry;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
